// ===== rtl/cbori_pkg.sv =====
// Package for the character/byte run index: types, codes and sizes.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package cbori_pkg;
   localparam int RUN_ENTRIES = 256;
   localparam int IDX_W = $clog2(RUN_ENTRIES);
   localparam int CNT_W = IDX_W + 1;
   localparam int LOC_W = 31;
   localparam int LEN_W = 8;
   localparam logic [LOC_W-1:0] LOC_MAX = {LOC_W{1'b1}};

   typedef enum logic [1:0] {
      OP_UPDATE = 2'd0,
      OP_C2B    = 2'd1,
      OP_B2C    = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_DONE    = 3'd0,
      ST_IGNORED = 3'd1,
      ST_GAP     = 3'd2,
      ST_FULL    = 3'd3,
      ST_BEYOND  = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]       op;
      logic [LOC_W-1:0] char_loc;
      logic [LOC_W-1:0] byte_loc;
      logic [LEN_W-1:0] char_len;
   } req_type;

   typedef struct packed {
      logic [LOC_W-1:0] mapped_loc;
      logic [2:0]       status;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LAST_RD,
      S_LAST_CHK,
      S_PROBE_RD,
      S_PROBE_CHK,
      S_INT_RD,
      S_INT_LOAD,
      S_DIV,
      S_MUL,
      S_SAT,
      S_DONE
   } state_type;

   // Request from the sequencer to the divide unit.
   typedef struct packed {
      logic             start;
      logic [LOC_W-1:0] dividend;
      logic [LEN_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic             done;
      logic [LOC_W-1:0] quotient;
   } div_sts_type;
endpackage

// ===== rtl/cbori_div.sv =====
// Restoring divider, one quotient bit per cycle: 31-bit by 8-bit unsigned.
// Depends on cbori_pkg.
`timescale 1ns / 1ps
module cbori_div
   import cbori_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_sts_type sts
);
   logic [LOC_W-1:0] quo_ff, quo_in;
   logic [LEN_W:0]   rem_ff, rem_in;
   logic [LEN_W-1:0] dvs_ff, dvs_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [LEN_W:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[LEN_W-1:0], quo_ff[LOC_W-1]};
      if (cmd.start) begin
         quo_in  = cmd.dividend;
         rem_in  = '0;
         dvs_in  = cmd.divisor;
         cnt_in  = 5'(LOC_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[LOC_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[LOC_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign sts.done     = busy_ff && cnt_ff == '0;
   assign sts.quotient = trial >= {1'b0, dvs_ff} ?
                         {quo_ff[LOC_W-2:0], 1'b1} : {quo_ff[LOC_W-2:0], 1'b0};

   a_no_zero: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> dvs_ff != '0) else $error("divide by zero length");
   a_done_once: assert property (@(posedge clock) disable iff (reset)
      sts.done |=> !sts.done) else $error("divider done held");
   a_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> busy_ff) else $error("divider did not start");
endmodule

// ===== rtl/cbori_table.sv =====
// Run table memory: start character, start byte and length per run.
// One write port and one registered read port. Depends on cbori_pkg.
`timescale 1ns / 1ps
module cbori_table
   import cbori_pkg::*;
(
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [LOC_W-1:0] wr_char,
   input  logic [LOC_W-1:0] wr_byte,
   input  logic [LEN_W-1:0] wr_len,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [LOC_W-1:0] rd_char,
   output logic [LOC_W-1:0] rd_byte,
   output logic [LEN_W-1:0] rd_len
);
   logic [2*LOC_W+LEN_W-1:0] mem [RUN_ENTRIES];
   logic [2*LOC_W+LEN_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_char, wr_byte, wr_len};
      end
      rd_ff <= mem[rd_addr];
   end

   assign {rd_char, rd_byte, rd_len} = rd_ff;
endmodule

// ===== rtl/char_byte_offset_run_index.sv =====
// Top level of the character/byte run index: sequencer, end registers.
// Uses cbori_pkg, cbori_table and cbori_div.
// Accept to strobe: update and clear go to S_DONE; a query answered from the cached end or an
// empty index passes S_LAST_RD; one through the last run adds S_LAST_CHK, S_INT_LOAD, S_MUL
// (char to byte) or S_DIV (byte to char) and S_SAT; a search adds S_PROBE_RD and S_PROBE_CHK
// per probe (up to 9) and S_INT_RD to reread the run. Busy holds through the strobe; the next
// word is taken in the cycle after it; results cannot be held off. Reset empties the index.
`timescale 1ns / 1ps
module char_byte_offset_run_index
   import cbori_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_word,
   output logic    rsp_valid,
   output rsp_type rsp_word
);
   state_type state_ff, state_in;
   req_type   req_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [LOC_W:0]   end_char_ff, end_char_in, end_byte_ff, end_byte_in;
   logic [LEN_W-1:0] cur_len_ff, cur_len_in;
   logic signed [CNT_W:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [LOC_W-1:0] res_ff, res_in;
   logic [2:0]       st_ff, st_in;
   logic [LOC_W-1:0] base_ff, base_in, diff_ff, diff_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LOC_W+LEN_W:0] acc_ff, acc_in;

   logic             tbl_wr;
   logic [IDX_W-1:0] rd_addr;
   logic [LOC_W-1:0] rd_char, rd_byte;
   logic [LEN_W-1:0] rd_len;
   div_cmd_type      dcmd;
   div_sts_type      dsts;

   logic             to_byte;
   logic [LOC_W-1:0] tgt, key, oth;
   logic [LOC_W:0]   end_key, end_oth;
   logic [LEN_W-1:0] ulen;
   logic             accept;
   logic signed [CNT_W:0] mid;

   assign accept  = start && !busy;
   assign to_byte = req_ff.op == OP_C2B;
   assign tgt     = to_byte ? req_ff.char_loc : req_ff.byte_loc;
   assign key     = to_byte ? rd_char : rd_byte;
   assign oth     = to_byte ? rd_byte : rd_char;
   assign end_key = to_byte ? end_char_ff : end_byte_ff;
   assign end_oth = to_byte ? end_byte_ff : end_char_ff;
   // The table is written in the accepting cycle, straight from the incoming word.
   assign ulen    = req_word.char_len == '0 ? LEN_W'(1) : req_word.char_len;
   assign mid     = (lo_ff + hi_ff) >>> 1;

   cbori_table u_table (
      .clock(clock), .wr_en(tbl_wr), .wr_addr(count_ff[IDX_W-1:0]),
      .wr_char(req_word.char_loc), .wr_byte(req_word.byte_loc), .wr_len(ulen),
      .rd_addr(rd_addr), .rd_char(rd_char), .rd_byte(rd_byte), .rd_len(rd_len)
   );

   cbori_div u_div (.clock(clock), .reset(reset), .cmd(dcmd), .sts(dsts));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) begin
            state_in = OP_UPDATE == req_word.op || OP_CLEAR == req_word.op ?
                       S_DONE : S_LAST_RD;
         end
         S_LAST_RD: begin
            if ({1'b0, tgt} == end_key || $signed({1'b0, tgt}) > $signed(end_key)
                || count_ff == '0) begin
               state_in = S_DONE;
            end else begin
               state_in = S_LAST_CHK;
            end
         end
         S_LAST_CHK:  state_in = tgt >= key ? S_INT_LOAD : S_PROBE_RD;
         S_PROBE_RD:  state_in = lo_ff <= hi_ff ? S_PROBE_CHK :
                                 (hi_ff < 0 ? S_DONE : S_INT_RD);
         S_PROBE_CHK: state_in = key == tgt ? S_DONE : S_PROBE_RD;
         S_INT_RD:    state_in = S_INT_LOAD;
         S_INT_LOAD:  state_in = to_byte ? S_MUL : S_DIV;
         S_DIV:       if (dsts.done) begin
            state_in = S_SAT;
         end
         S_MUL:       state_in = S_SAT;
         S_SAT:       state_in = S_DONE;
         S_DONE:      state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      count_in    = count_ff;
      end_char_in = end_char_ff;
      end_byte_in = end_byte_ff;
      cur_len_in  = cur_len_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      res_in      = res_ff;
      st_in       = st_ff;
      base_in     = base_ff;
      diff_in     = diff_ff;
      len_in      = len_ff;
      acc_in      = acc_ff;
      tbl_wr      = 1'b0;
      rd_addr     = IDX_W'(count_ff - CNT_W'(1));
      dcmd        = '{start: 1'b0, dividend: diff_ff, divisor: len_ff};
      case (state_ff)
         S_IDLE: if (accept) begin
            res_in = '0;
            st_in  = ST_DONE;
            if (req_word.op == OP_CLEAR) begin
               count_in    = '0;
               end_char_in = '1;
               end_byte_in = '1;
               cur_len_in  = '0;
            end else if (req_word.op == OP_UPDATE) begin
               if ($signed({1'b0, req_word.char_loc}) <= $signed(end_char_ff)) begin
                  st_in = ST_IGNORED;
               end else if ((req_word.char_len == '0 ? LEN_W'(1) : req_word.char_len)
                            != cur_len_ff && count_ff == CNT_W'(RUN_ENTRIES)) begin
                  st_in = ST_FULL;
               end else begin
                  if ((req_word.char_len == '0 ? LEN_W'(1) : req_word.char_len)
                      != cur_len_ff) begin
                     count_in = count_ff + CNT_W'(1);
                  end
                  end_char_in = {1'b0, req_word.char_loc};
                  end_byte_in = {1'b0, req_word.byte_loc};
                  cur_len_in  = req_word.char_len == '0 ? LEN_W'(1) : req_word.char_len;
                  st_in = {1'b0, req_word.char_loc} != end_char_ff + (LOC_W+1)'(1) ?
                          ST_GAP : ST_DONE;
               end
            end
         end
         S_LAST_RD: begin
            if ({1'b0, tgt} == end_key) begin
               res_in = end_oth[LOC_W-1:0];
            end else if ($signed({1'b0, tgt}) > $signed(end_key)) begin
               st_in = ST_BEYOND;
            end else if (count_ff == '0) begin
               res_in = tgt;
            end
            lo_in = '0;
            hi_in = (CNT_W+1)'(count_ff) - (CNT_W+1)'(1);
         end
         S_PROBE_RD: begin
            rd_addr = IDX_W'(mid);
            if (!(lo_ff <= hi_ff)) begin
               if (hi_ff < 0) begin
                  res_in = tgt;
               end
               rd_addr = IDX_W'(hi_ff);
            end
         end
         S_PROBE_CHK: begin
            if (key == tgt) begin
               res_in = oth;
            end else if (key > tgt) begin
               hi_in = mid - (CNT_W+1)'(1);
            end else begin
               lo_in = mid + (CNT_W+1)'(1);
            end
         end
         S_INT_RD: begin
            // Hold the address so the chosen run is still on the read port next cycle.
            rd_addr = IDX_W'(hi_ff);
         end
         S_INT_LOAD: begin
            base_in = oth;
            diff_in = tgt - key;
            len_in  = rd_len == '0 ? LEN_W'(1) : rd_len;
         end
         S_MUL: begin
            acc_in = (LOC_W+LEN_W+1)'(base_ff) + (LOC_W+LEN_W+1)'(diff_ff * len_ff);
         end
         S_DIV: begin
            if (dsts.done) begin
               acc_in = (LOC_W+LEN_W+1)'(base_ff) + (LOC_W+LEN_W+1)'(dsts.quotient);
            end
         end
         S_SAT: begin
            res_in = acc_ff > (LOC_W+LEN_W+1)'(LOC_MAX) ? LOC_MAX : acc_ff[LOC_W-1:0];
         end
         default: begin
         end
      endcase
      if (state_ff == S_INT_LOAD && !to_byte) begin
         dcmd.start    = 1'b1;
         dcmd.dividend = tgt - key;
         dcmd.divisor  = rd_len == '0 ? LEN_W'(1) : rd_len;
      end
      if (state_ff == S_IDLE && accept && req_word.op == OP_UPDATE
          && $signed({1'b0, req_word.char_loc}) > $signed(end_char_ff)
          && (req_word.char_len == '0 ? LEN_W'(1) : req_word.char_len) != cur_len_ff
          && count_ff != CNT_W'(RUN_ENTRIES)) begin
         tbl_wr = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_word;
      end
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      res_ff  <= res_in;
      st_ff   <= st_in;
      base_ff <= base_in;
      diff_ff <= diff_in;
      len_ff  <= len_in;
      acc_ff  <= acc_in;
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         end_char_ff <= '1;
         end_byte_ff <= '1;
         cur_len_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         end_char_ff <= end_char_in;
         end_byte_ff <= end_byte_in;
         cur_len_ff  <= cur_len_in;
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_DONE;
   assign rsp_word  = '{mapped_loc: res_ff, status: st_ff};

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RUN_ENTRIES)) else $error("run count overflow");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> !rsp_valid || $past(req_word.op) == OP_UPDATE
                 || $past(req_word.op) == OP_CLEAR)
      else $error("response too early");
   a_beyond_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == ST_BEYOND |-> rsp_word.mapped_loc == '0)
      else $error("beyond end with answer");
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      tbl_wr |-> state_ff == S_IDLE) else $error("table write while busy");
endmodule

// ===== test/char_byte_offset_run_index_chk.sv =====
// Checker for the character/byte run index: watches the word and result channels,
// predicts each result from its own copy of the index and compares. Uses cbori_pkg.
`timescale 1ns / 1ps
module char_byte_offset_run_index_chk
   import cbori_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_word,
   input  logic    rsp_valid,
   input  rsp_type rsp_word,
   output int      fail_count,
   output int      pending
);
   logic [LOC_W-1:0] idx_char [RUN_ENTRIES];
   logic [LOC_W-1:0] idx_byte [RUN_ENTRIES];
   logic [LEN_W-1:0] idx_len  [RUN_ENTRIES];
   int unsigned      idx_count;
   longint           last_char, last_byte;
   logic [LEN_W-1:0] last_len;
   rsp_type          expected_rsp [$];

   initial begin
      fail_count = 0;
      pending = 0;
   end

   task automatic report(input string what);
      $display("%0t: mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   function automatic logic [LOC_W-1:0] clip(input longint unsigned v);
      return (v > LOC_MAX) ? LOC_MAX : v[LOC_W-1:0];
   endfunction

   function automatic logic [LOC_W-1:0] map_in_run(input logic [LOC_W-1:0] t,
                                                   input int i, input bit to_byte);
      longint unsigned len;
      len = (idx_len[i] == 0) ? 1 : idx_len[i];
      if (to_byte)
         return clip(longint'(idx_byte[i]) + len * longint'(t - idx_char[i]));
      return clip(longint'(idx_char[i]) + longint'(t - idx_byte[i]) / len);
   endfunction

   function automatic rsp_type map_loc(input logic [LOC_W-1:0] t, input bit to_byte);
      rsp_type r;
      longint  end_key, end_other;
      int      lo, hi, mid;
      logic [LOC_W-1:0] probe;
      r = '0;
      end_key = to_byte ? last_char : last_byte;
      end_other = to_byte ? last_byte : last_char;
      if (longint'(t) == end_key) begin
         r.mapped_loc = end_other[LOC_W-1:0];
         return r;
      end
      if (longint'(t) > end_key) begin
         r.status = ST_BEYOND;
         return r;
      end
      if (idx_count == 0) begin
         r.mapped_loc = t;
         return r;
      end
      if (t >= (to_byte ? idx_char[idx_count-1] : idx_byte[idx_count-1])) begin
         r.mapped_loc = map_in_run(t, idx_count - 1, to_byte);
         return r;
      end
      lo = 0;
      hi = idx_count - 1;
      while (lo <= hi) begin
         mid = (lo + hi) / 2;
         probe = to_byte ? idx_char[mid] : idx_byte[mid];
         if (probe == t) begin
            r.mapped_loc = to_byte ? idx_byte[mid] : idx_char[mid];
            return r;
         end
         if (probe > t) hi = mid - 1;
         else lo = mid + 1;
      end
      r.mapped_loc = (hi < 0) ? t : map_in_run(t, hi, to_byte);
      return r;
   endfunction

   function automatic rsp_type apply_word(input req_type w);
      rsp_type          r;
      logic [LEN_W-1:0] len;
      bit               gap;
      r = '0;
      case (op_type'(w.op))
         OP_UPDATE: begin
            if (longint'(w.char_loc) <= last_char) begin
               r.status = ST_IGNORED;
            end else begin
               gap = longint'(w.char_loc) != last_char + 1;
               len = (w.char_len == 0) ? LEN_W'(1) : w.char_len;
               if (len != last_len && idx_count >= RUN_ENTRIES) begin
                  r.status = ST_FULL;
                  return r;
               end
               if (len != last_len) begin
                  idx_char[idx_count] = w.char_loc;
                  idx_byte[idx_count] = w.byte_loc;
                  idx_len[idx_count] = len;
                  idx_count++;
               end
               last_char = w.char_loc;
               last_byte = w.byte_loc;
               last_len = len;
               r.status = gap ? ST_GAP : ST_DONE;
            end
         end
         OP_C2B: r = map_loc(w.char_loc, 1'b1);
         OP_B2C: r = map_loc(w.byte_loc, 1'b0);
         default: begin
            idx_count = 0;
            last_char = -1;
            last_byte = -1;
            last_len = 0;
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         idx_count = 0;
         last_char = -1;
         last_byte = -1;
         last_len = 0;
         expected_rsp.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_rsp.size() == 0) begin
               report("result with no word outstanding");
            end else begin
               e = expected_rsp.pop_front();
               if (rsp_word.mapped_loc !== e.mapped_loc)
                  report($sformatf("mapped_loc %0d, expected %0d",
                                   rsp_word.mapped_loc, e.mapped_loc));
               if (rsp_word.status !== e.status)
                  report($sformatf("status %0d, expected %0d",
                                   rsp_word.status, e.status));
            end
         end
         if (start && !busy) expected_rsp.push_back(apply_word(req_word));
      end
      pending = expected_rsp.size();
   end
endmodule

// ===== test/char_byte_offset_run_index_tb.sv =====
// Testbench top for the character/byte run index: clock, reset, stimulus, verdict.
// Uses cbori_pkg, the block and char_byte_offset_run_index_chk.
`timescale 1ns / 1ps
module char_byte_offset_run_index_tb;
   import cbori_pkg::*;

   localparam int STALL_LIMIT = 4000;

   logic    clock, reset, start, busy, rsp_valid;
   req_type req_word;
   rsp_type rsp_word;
   int      fail_count, pending, quiet_cycles;
   bit      calm;

   // Text position the random stream has reached.
   longint unsigned text_char, text_byte;
   int unsigned     text_len;

   char_byte_offset_run_index u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_valid(rsp_valid), .rsp_word(rsp_word)
   );

   char_byte_offset_run_index_chk u_chk (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_valid(rsp_valid), .rsp_word(rsp_word),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Start stays high after the accepting edge; the block is busy then, and the next
   // call either drops it for an idle gap or puts up the next word.
   task automatic send(input op_type op, input logic [LOC_W-1:0] c,
                       input logic [LOC_W-1:0] b, input logic [LEN_W-1:0] len);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 12);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_word <= '{op: op, char_loc: c, byte_loc: b, char_len: len};
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_drained();
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Mostly well-formed text: updates, queries near the end, random words, clears.
   task automatic text_step();
      int unsigned k;
      longint unsigned t;
      k = $urandom_range(0, 99);
      if (k < 45) begin
         if ($urandom_range(0, 4) == 0) text_len = $urandom_range(1, 255);
         if ($urandom_range(0, 19) == 0) begin
            text_char += $urandom_range(2, 50);
            text_byte += $urandom_range(2, 50);
         end
         if (text_char > 64'h7000_0000 || text_byte > 64'h7000_0000) begin
            send(OP_CLEAR, LOC_W'($urandom), LOC_W'($urandom), LEN_W'($urandom));
            text_char = 0;
            text_byte = 0;
         end
         send(OP_UPDATE, LOC_W'(text_char), LOC_W'(text_byte),
              ($urandom_range(0, 30) == 0) ? 8'd0 : text_len[LEN_W-1:0]);
         text_char += 1;
         text_byte += (text_len == 0) ? 1 : text_len;
      end else if (k < 70) begin
         t = (text_char == 0) ? 0 : $urandom_range(0, 32'(text_char + 2));
         send(OP_C2B, LOC_W'(t), LOC_W'($urandom), LEN_W'($urandom));
      end else if (k < 94) begin
         t = (text_byte == 0) ? 0 : $urandom_range(0, 32'(text_byte + 2));
         send(OP_B2C, LOC_W'($urandom), LOC_W'(t), LEN_W'($urandom));
      end else if (k < 97) begin
         send(op_type'($urandom_range(0, 2)), LOC_W'($urandom), LOC_W'($urandom),
              LEN_W'($urandom));
      end else begin
         send(OP_CLEAR, LOC_W'($urandom), LOC_W'($urandom), LEN_W'($urandom));
         text_char = 0;
         text_byte = 0;
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_word = '0;
      calm = 1'b0;
      quiet_cycles = 0;
      text_char = 0;
      text_byte = 0;
      text_len = 1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty index and past-end queries, then updates, run queries and a clear.
      send(OP_C2B, 0, 0, 0);
      send(OP_B2C, 0, 0, 0);
      send(OP_C2B, LOC_MAX, 0, 0);
      send(OP_UPDATE, 0, 0, 0);
      send(OP_UPDATE, 0, 5, 3);
      send(OP_UPDATE, 1, 1, 3);
      send(OP_UPDATE, 10, 40, 255);
      send(OP_UPDATE, 11, 295, 2);
      send(OP_C2B, 5, 0, 0);
      send(OP_B2C, 0, 3, 0);
      send(OP_C2B, 10, 0, 0);
      send(OP_B2C, 0, 295, 0);
      send(OP_C2B, 12, 0, 0);
      send(OP_UPDATE, LOC_MAX - LOC_W'(1), 31'h7FFF_FF00, 255);
      send(OP_C2B, LOC_MAX - LOC_W'(1), 0, 0);
      send(OP_C2B, 31'h4000_0000, 0, 0);
      send(OP_B2C, 0, 31'h7FFF_FFF0, 0);
      send(OP_UPDATE, LOC_MAX, LOC_MAX, 1);
      send(OP_B2C, 0, LOC_MAX, 0);
      send(OP_CLEAR, LOC_MAX, LOC_MAX, 8'hFF);
      send(OP_C2B, 3, 0, 0);

      // Fill the table, then overflow it.
      for (int i = 0; i <= RUN_ENTRIES; i++)
         send(OP_UPDATE, LOC_W'(i), LOC_W'(2 * i), (i % 2) ? 8'd1 : 8'd2);
      send(OP_C2B, 100, 0, 0);
      send(OP_B2C, 0, 301, 0);
      send(OP_CLEAR, 0, 0, 0);

      for (int n = 0; n < 220; n++) begin
         if (n == 180) calm = 1'b1;
         text_step();
      end
      start <= 1'b0;
      wait_drained();
      repeat (60) @(posedge clock);

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
